// ===== design/u16u8_pkg.sv =====
// shared types and constants for the utf-16le to utf-8 encoder
// no dependencies
package u16u8_pkg;

  localparam int unsigned CapW        = 13;
  localparam int unsigned MaxCapacity = 4096;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned MaxBytes    = 4;
  localparam int unsigned CntW        = $clog2(MaxBytes + 1);

  localparam logic [CapW-1:0] CapReset  = 13'd512;
  localparam logic [CapW-1:0] CapMax    = CapW'(MaxCapacity);
  localparam logic [15:0]     Lim1Byte  = 16'h0080;
  localparam logic [15:0]     Lim2Byte  = 16'h0800;
  localparam logic [7:0]      Lead2     = 8'hc0;
  localparam logic [7:0]      Lead3     = 8'he0;
  localparam logic [7:0]      ContMark  = 8'h80;
  localparam logic [7:0]      ContMask  = 8'h3f;
  localparam logic [7:0]      TermByte  = 8'h00;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
    logic                     trunc;
  } job_t;

endpackage

// ===== design/u16u8_front.sv =====
// front end: capacity register, string state and per-unit classification
// depends on u16u8_pkg
module u16u8_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [12:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [15:0]            code_unit_i,
  input  logic                   last_unit_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output u16u8_pkg::job_t        q_job_o
);
  import u16u8_pkg::*;

  logic [CapW-1:0] cap_q, cap_eff;
  logic [CapW-1:0] bw_q, bw_d;
  logic            stop_q, stop_d;
  logic [1:0]      need;
  logic            room;
  logic            accept;
  logic [CapW:0]   sum;
  job_t            job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cap_eff    = (cap_q > CapMax) ? CapMax : cap_q;
  assign need       = (code_unit_i < Lim1Byte) ? 2'd1 :
                      (code_unit_i < Lim2Byte) ? 2'd2 : 2'd3;
  assign sum        = {1'b0, bw_q} + {{(CapW-1){1'b0}}, need};
  assign room       = sum < {1'b0, cap_eff};

  always_comb begin
    job    = '0;
    bw_d   = bw_q;
    stop_d = stop_q;
    if (!stop_q) begin
      if (code_unit_i == 16'h0000) begin
        job.bytes[0] = TermByte;
        job.cnt      = CntW'(1);
        stop_d       = 1'b1;
      end else if (!room) begin
        job.bytes[0] = TermByte;
        job.trunc    = 1'b1;
        job.cnt      = CntW'(1);
        stop_d       = 1'b1;
      end else begin
        case (need)
          2'd1: begin
            job.bytes[0] = code_unit_i[7:0];
          end
          2'd2: begin
            job.bytes[0] = Lead2 | {3'b000, code_unit_i[10:6]};
            job.bytes[1] = ContMark | ({2'b00, code_unit_i[5:0]} & ContMask);
          end
          default: begin
            job.bytes[0] = Lead3 | {4'b0000, code_unit_i[15:12]};
            job.bytes[1] = ContMark | ({2'b00, code_unit_i[11:6]} & ContMask);
            job.bytes[2] = ContMark | ({2'b00, code_unit_i[5:0]} & ContMask);
          end
        endcase
        job.cnt = CntW'(need);
        bw_d    = sum[CapW-1:0];
      end
    end
    if (last_unit_i) begin
      if (!stop_d) begin
        job.bytes[job.cnt[1:0]] = TermByte;
        job.cnt                 = job.cnt + CntW'(1);
      end
      bw_d   = '0;
      stop_d = 1'b0;
    end
  end

  assign q_push_o = accept && (job.cnt != '0);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapReset;
      bw_q   <= '0;
      stop_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        bw_q   <= bw_d;
        stop_q <= stop_d;
      end
    end
  end

endmodule

// ===== design/u16u8_queue.sv =====
// short job queue between front end and byte serializer
// depends on u16u8_pkg
module u16u8_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output u16u8_pkg::job_t head_o
);
  import u16u8_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QueuePtrW'(1);
      if (do_pop)  rd_q <= rd_q + QueuePtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QueuePtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QueuePtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/u16u8_back.sv =====
// back end: walks the bytes of each queued job onto the output register
// depends on u16u8_pkg
module u16u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  u16u8_pkg::job_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o,
  output logic            truncated_o
);
  import u16u8_pkg::*;

  logic [1:0] idx_q;
  logic       ov_q;
  logic [7:0] byte_q;
  logic       last_q, trunc_q;
  logic       load, at_end;

  assign load    = !q_empty_i && (!ov_q || out_ready_i);
  assign at_end  = ({1'b0, idx_q} + CntW'(1)) == q_head_i.cnt;
  assign q_pop_o = load && at_end;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= q_head_i.bytes[idx_q];
      last_q  <= at_end;
      trunc_q <= q_head_i.trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;
  assign truncated_o = trunc_q;

endmodule

// ===== design/utf16le_to_utf8_encoder.sv =====
// utf-16le to utf-8 encoder, top level: front end, job queue, byte serializer
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
// path: an accepted unit's job is written into the job queue, then its bytes into the output register
// throughput: one output byte per cycle, set by the byte-wide output register, while the
//   receiver is ready and the queue holds a job; a unit yields 0 to 4 bytes
// reset: asynchronous, clears string state and queue, capacity back to 512
module utf16le_to_utf8_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic        truncated_o
);
  import u16u8_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  job_t push_job, head_job;

  u16u8_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .code_unit_i, .last_unit_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (push_job)
  );

  u16u8_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_job)
  );

  u16u8_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .q_head_i  (head_job),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i, .out_byte_o, .last_byte_o, .truncated_o
  );

  // a forced terminator is a lone zero byte
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> last_byte_o && out_byte_o == TermByte)
    else $error("truncated byte not a final terminator");

  // remaining bytes of a request follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_byte_o |=> out_valid_o)
    else $error("gap inside a request's bytes");

  // nothing is pushed while the queue is full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("push into full queue");

endmodule

// ===== verif/tb_top.sv =====
// testbench for utf16le_to_utf8_encoder: directed and random code unit strings
// checked byte by byte against a predictor kept in step with accepted requests
// depends on u16u8_pkg and the encoder rtl
`timescale 1ns / 100ps

module tb_top;
  import u16u8_pkg::*;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } unit_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } utf8_byte_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  logic [15:0]     code_unit_i = '0;
  logic            last_unit_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      out_byte_o;
  logic            last_byte_o;
  logic            truncated_o;

  unit_req_t  pending_units[$];
  utf8_byte_t expected_bytes[$];

  logic [CapW-1:0] cap_setting = CapReset;
  int unsigned     str_len     = 0;
  logic            str_stopped = 1'b0;

  int   mismatch_count = 0;
  logic no_idle        = 1'b0;
  int   stall_requests = 0;
  int   stalls_served  = 0;
  int   hold_left      = 0;
  int   added          = 0;

  utf16le_to_utf8_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .truncated_o (truncated_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL utf16le_to_utf8_encoder");
    $finish;
  end

  task automatic report(input string msg);
    if (mismatch_count < 40) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // utf-8 bytes caused by one accepted request, updates string state
  task automatic encode_unit(input logic [15:0] cu, input logic lst);
    utf8_byte_t  res[$];
    int unsigned need;
    int unsigned cap;
    cap = (cap_setting > MaxCapacity) ? MaxCapacity : cap_setting;
    if (!str_stopped) begin
      if (cu == 16'h0000) begin
        res.push_back('{TermByte, 1'b0, 1'b0});
        str_stopped = 1'b1;
      end else begin
        need = (cu < Lim1Byte) ? 1 : (cu < Lim2Byte) ? 2 : 3;
        if (str_len + need >= cap) begin
          res.push_back('{TermByte, 1'b0, 1'b1});
          str_stopped = 1'b1;
        end else begin
          case (need)
            1: begin
              res.push_back('{cu[7:0], 1'b0, 1'b0});
            end
            2: begin
              res.push_back('{Lead2 | {3'b0, cu[10:6]}, 1'b0, 1'b0});
              res.push_back('{ContMark | {2'b0, cu[5:0]}, 1'b0, 1'b0});
            end
            default: begin
              res.push_back('{Lead3 | {4'b0, cu[15:12]}, 1'b0, 1'b0});
              res.push_back('{ContMark | {2'b0, cu[11:6]}, 1'b0, 1'b0});
              res.push_back('{ContMark | {2'b0, cu[5:0]}, 1'b0, 1'b0});
            end
          endcase
          str_len += need;
        end
      end
    end
    if (lst) begin
      if (!str_stopped) res.push_back('{TermByte, 1'b0, 1'b0});
      str_len     = 0;
      str_stopped = 1'b0;
    end
    if (res.size() != 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_bytes.push_back(res[i]);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_units
    unit_req_t u;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) encode_unit(code_unit_i, last_unit_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_units.size() != 0 && (no_idle || $urandom_range(99) >= 16)) begin
          u = pending_units.pop_front();
          in_valid_i  <= 1'b1;
          code_unit_i <= u.code;
          last_unit_i <= u.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else if (stall_requests != stalls_served) begin
      stalls_served <= stall_requests;
      hold_left     <= 80;
      out_ready_i   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  // byte monitor
  always @(posedge clk_i) begin : check_bytes
    utf8_byte_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h last %b trunc %b",
                         out_byte_o, last_byte_o, truncated_o));
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte_o !== e.data || last_byte_o !== e.last || truncated_o !== e.trunc)
          report($sformatf("got byte %h last %b trunc %b, want %h %b %b",
                           out_byte_o, last_byte_o, truncated_o,
                           e.data, e.last, e.trunc));
      end
    end
  end

  task automatic push_unit(input logic [15:0] c, input logic l);
    pending_units.push_back('{c, l});
    added++;
  endtask

  task automatic wait_idle();
    while (pending_units.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    cap_setting = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one string of random units, sometimes cut short by a zero unit
  task automatic add_string(input int maxlen);
    int          len;
    int          r;
    logic [15:0] c;
    len = $urandom_range(1, maxlen);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 35)      c = 16'($urandom_range(1, 127));
      else if (r < 60) c = 16'($urandom_range(128, 2047));
      else if (r < 93) c = 16'($urandom_range(2048, 65535));
      else             c = 16'h0000;
      push_unit(c, i == len - 1);
    end
  endtask

  initial begin : run_phases
    logic [CapW-1:0] caps[6];
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    write_capacity(CapReset);
    push_unit(16'h0041, 1'b0);
    push_unit(16'h007f, 1'b0);
    push_unit(16'h0080, 1'b0);
    push_unit(16'h07ff, 1'b0);
    push_unit(16'h0800, 1'b0);
    push_unit(16'hd800, 1'b0);
    push_unit(16'hdfff, 1'b0);
    push_unit(16'hffff, 1'b0);
    push_unit(16'h0001, 1'b1);
    push_unit(16'h0000, 1'b0);
    push_unit(16'h0041, 1'b0);
    push_unit(16'h1234, 1'b1);
    push_unit(16'h0000, 1'b1);
    push_unit(16'h5555, 1'b1);
    push_unit(16'haaaa, 1'b1);
    wait_idle();

    write_capacity(13'd4);
    push_unit(16'h0041, 1'b0);
    push_unit(16'h0042, 1'b0);
    push_unit(16'h0043, 1'b0);
    push_unit(16'h0044, 1'b0);
    push_unit(16'h0045, 1'b1);
    push_unit(16'h07ff, 1'b1);
    wait_idle();

    write_capacity(13'd0);
    push_unit(16'h0041, 1'b1);
    push_unit(16'h0000, 1'b1);
    wait_idle();

    write_capacity(13'h1fff);
    push_unit(16'hffff, 1'b0);
    push_unit(16'h0800, 1'b1);
    wait_idle();

    write_capacity(13'd1);
    push_unit(16'h0041, 1'b1);
    wait_idle();

    caps[0] = CapMax;
    caps[1] = CapW'($urandom_range(2, 24));
    caps[2] = CapW'($urandom_range(2, 40));
    caps[3] = 13'h1fff;
    caps[4] = 13'd3;
    caps[5] = CapW'($urandom_range(1, 16));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      no_idle = (p == 2);
      if (p == 3) stall_requests++;
      added = 0;
      while (added < 30) add_string(10);
      wait_idle();
      no_idle = 1'b0;
    end

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS utf16le_to_utf8_encoder");
    end else begin
      $display("FAIL utf16le_to_utf8_encoder");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16le_to_utf8_encoder.sv
verif/tb_top.sv
